[hw/rtl/tpad_pkg.sv]
package tpad_pkg;

    localparam int COUNT_WIDTH = 8;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_ZERO_CROSS = 2'd1;
    localparam logic [1:0] CMD_LEVEL      = 2'd2;

    localparam logic [1:0] REG_PULSE_WIDTH = 2'd0;
    localparam logic [1:0] REG_LOW_CUTOFF  = 2'd1;
    localparam logic [1:0] REG_HIGH_LIMIT  = 2'd2;

    localparam logic [7:0] PULSE_WIDTH_RST = 8'd20;
    localparam logic [7:0] LOW_CUTOFF_RST  = 8'd5;
    localparam logic [6:0] HIGH_LIMIT_RST  = 7'd99;
    localparam logic [7:0] DELAY_RST       = 8'd78;

    localparam logic [10:0] DELAY_BASE  = 11'd1330;
    localparam logic [10:0] DELAY_SLOPE = 11'd13;
    // 6554 / 2^16 ~ 1/10, exact for dividends up to 1330
    localparam logic [23:0] RECIP_TEN   = 24'd6554;

    typedef struct packed {
        logic       gate;
        logic       echo_valid;
        logic [7:0] echo_byte;
    } t_result;

    // firing delay in ticks for a clamped level, 0 means off
    function automatic logic [7:0] delay_of(input logic [6:0] level);
        logic [10:0] prod;
        logic [10:0] diff;
        logic [23:0] scaled;
        prod   = 11'(level) * DELAY_SLOPE;
        diff   = DELAY_BASE - prod;
        scaled = 24'(diff) * RECIP_TEN;
        if (level == 7'd0 || prod >= DELAY_BASE) begin
            return 8'd0;
        end
        return scaled[23:16];
    endfunction

endpackage

[hw/rtl/triac_phase_angle_dimmer_core.sv]
// Each accepted input beat yields one result beat, taken from a register.
// Throughput: one beat per cycle while o_stall and i_stall are low; state
// update and level-to-delay mapping complete in the accept cycle, results
// leave through an output register backed by a one-entry skid register.
// Reset (i_rst_n low, synchronous): registers return to defaults, counters
// stop, gate low, no result pending.
module triac_phase_angle_dimmer_core
    import tpad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_level_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_gate,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte
);

    logic [7:0]             r_pulse_width;
    logic [7:0]             r_low_cutoff;
    logic [6:0]             r_high_limit;

    logic [7:0]             r_pending_delay, n_pending_delay;
    logic [7:0]             r_active_delay,  n_active_delay;
    logic [COUNT_WIDTH-1:0] r_delay_count,   n_delay_count;
    logic                   r_delay_running, n_delay_running;
    logic [COUNT_WIDTH-1:0] r_pulse_count,   n_pulse_count;
    logic                   r_pulse_running, n_pulse_running;
    logic                   r_gate_level,    n_gate_level;

    t_result                r_out, r_skid, n_res;
    logic                   r_out_valid, r_skid_valid;

    logic                   in_fire;
    logic                   out_fire;
    logic [6:0]             clamped;

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    always_comb begin
        if (i_level_byte < r_low_cutoff) begin
            clamped = 7'd0;
        end else if (i_level_byte > {1'b0, r_high_limit}) begin
            clamped = r_high_limit;
        end else begin
            clamped = i_level_byte[6:0];
        end
    end

    always_comb begin
        n_pending_delay = r_pending_delay;
        n_active_delay  = r_active_delay;
        n_delay_count   = r_delay_count;
        n_delay_running = r_delay_running;
        n_pulse_count   = r_pulse_count;
        n_pulse_running = r_pulse_running;
        n_gate_level    = r_gate_level;
        n_res.echo_valid = 1'b0;
        n_res.echo_byte  = 8'd0;
        case (i_command)
            CMD_TICK: begin
                if (r_pulse_running) begin
                    n_pulse_count = r_pulse_count + COUNT_WIDTH'(1);
                    if (n_pulse_count == COUNT_WIDTH'(r_pulse_width)) begin
                        n_gate_level    = 1'b0;
                        n_pulse_running = 1'b0;
                    end
                end
                if (r_delay_running) begin
                    n_delay_count = r_delay_count + COUNT_WIDTH'(1);
                    if (n_delay_count == COUNT_WIDTH'(r_active_delay)) begin
                        n_gate_level    = 1'b1;
                        n_pulse_count   = '0;
                        n_pulse_running = 1'b1;
                        n_delay_running = 1'b0;
                    end
                end
            end
            CMD_ZERO_CROSS: begin
                if (r_pending_delay != 8'd0) begin
                    n_active_delay  = r_pending_delay;
                    n_delay_count   = '0;
                    n_delay_running = 1'b1;
                end
            end
            CMD_LEVEL: begin
                n_pending_delay  = delay_of(clamped);
                n_res.echo_valid = 1'b1;
                n_res.echo_byte  = {1'b0, clamped};
            end
            default: begin
            end
        endcase
        n_res.gate = n_gate_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= PULSE_WIDTH_RST;
            r_low_cutoff  <= LOW_CUTOFF_RST;
            r_high_limit  <= HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PULSE_WIDTH: r_pulse_width <= i_cfg_data;
                REG_LOW_CUTOFF:  r_low_cutoff  <= i_cfg_data;
                REG_HIGH_LIMIT:  r_high_limit  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_delay <= DELAY_RST;
            r_active_delay  <= DELAY_RST;
            r_delay_count   <= '0;
            r_delay_running <= 1'b0;
            r_pulse_count   <= '0;
            r_pulse_running <= 1'b0;
            r_gate_level    <= 1'b0;
        end else if (in_fire) begin
            r_pending_delay <= n_pending_delay;
            r_active_delay  <= n_active_delay;
            r_delay_count   <= n_delay_count;
            r_delay_running <= n_delay_running;
            r_pulse_count   <= n_pulse_count;
            r_pulse_running <= n_pulse_running;
            r_gate_level    <= n_gate_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_gate       = r_out.gate;
    assign o_echo_valid = r_out.echo_valid;
    assign o_echo_byte  = r_out.echo_byte;

`ifndef SYNTHESIS
    a_gate_tracks_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate_level == r_pulse_running)
        else $error("gate level out of step with pulse counter");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_delay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay_running |-> (r_active_delay != 8'd0))
        else $error("delay counter running with zero delay");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !out_fire) |=> r_skid_valid)
        else $error("accepted beat lost while output stalled");
`endif

endmodule

[tb/tb_triac_phase_angle_dimmer_core.sv]
`timescale 1ns / 1ps

module tb_triac_phase_angle_dimmer_core
    import tpad_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int BEATS_PER_PHASE = 200;
    localparam int N_PHASES = 6;
    localparam int MAX_REPORTS = 10;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] lvl;
        logic       typed;
        logic       gate;
        logic       echo_valid;
        logic [7:0] echo_byte;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_command;
    logic [7:0] i_level_byte;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_gate;
    logic       o_echo_valid;
    logic [7:0] o_echo_byte;

    // predictor copy of configuration and state
    logic [7:0] cfg_pulse_width;
    logic [7:0] cfg_low_cutoff;
    logic [6:0] cfg_high_limit;
    logic [7:0] p_pending;
    logic [7:0] p_active;
    t_cnt       p_delay_cnt;
    logic       p_delay_on;
    t_cnt       p_pulse_cnt;
    logic       p_pulse_on;
    logic       p_gate;

    t_result gate_echo_q[$];
    int      errors = 0;
    int      beats_seen = 0;
    int      stall_seen = 0;
    int      stall_left = 0;
    int      stuck = 0;
    bit      calm = 1'b0;

    t_row directed [24] = '{
        '{CMD_TICK,       8'h00, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_UNUSED,     8'hFF, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_LEVEL,      8'h00, 1'b1, 1'b0, 1'b1, 8'd0},
        '{CMD_LEVEL,      8'h04, 1'b1, 1'b0, 1'b1, 8'd0},
        '{CMD_LEVEL,      8'h05, 1'b1, 1'b0, 1'b1, 8'd5},
        '{CMD_LEVEL,      8'hFF, 1'b1, 1'b0, 1'b1, 8'd99},
        '{CMD_LEVEL,      8'd100, 1'b1, 1'b0, 1'b1, 8'd99},
        '{CMD_LEVEL,      8'd99, 1'b1, 1'b0, 1'b1, 8'd99},
        '{CMD_ZERO_CROSS, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'hAA, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h55, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b1, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'hFF, 1'b1, 1'b1, 1'b0, 8'd0},
        '{CMD_ZERO_CROSS, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_LEVEL,      8'h02, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_ZERO_CROSS, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_LEVEL,      8'h55, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_LEVEL,      8'hAA, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 8'd0},
        '{CMD_UNUSED,     8'h00, 1'b0, 1'b0, 1'b0, 8'd0}
    };

    triac_phase_angle_dimmer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_level_byte(i_level_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_gate      (o_gate),
        .o_echo_valid(o_echo_valid),
        .o_echo_byte (o_echo_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic t_result dimmer_predict(input logic [1:0] cmd, input logic [7:0] lvl);
        t_result    r;
        logic [7:0] clamped;
        int         prod;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (p_pulse_on) begin
                    p_pulse_cnt = p_pulse_cnt + t_cnt'(1);
                    if (p_pulse_cnt == t_cnt'(cfg_pulse_width)) begin
                        p_gate     = 1'b0;
                        p_pulse_on = 1'b0;
                    end
                end
                if (p_delay_on) begin
                    p_delay_cnt = p_delay_cnt + t_cnt'(1);
                    if (p_delay_cnt == t_cnt'(p_active)) begin
                        p_gate      = 1'b1;
                        p_pulse_cnt = '0;
                        p_pulse_on  = 1'b1;
                        p_delay_on  = 1'b0;
                    end
                end
            end
            CMD_ZERO_CROSS: begin
                if (p_pending != 8'd0) begin
                    p_active    = p_pending;
                    p_delay_cnt = '0;
                    p_delay_on  = 1'b1;
                end
            end
            CMD_LEVEL: begin
                if (lvl < cfg_low_cutoff) begin
                    clamped = 8'd0;
                end else if (lvl > {1'b0, cfg_high_limit}) begin
                    clamped = {1'b0, cfg_high_limit};
                end else begin
                    clamped = lvl;
                end
                prod = 13 * int'(clamped);
                // zero level or a product at or past the base means off
                p_pending = (clamped == 8'd0 || prod >= 1330) ? 8'd0 : 8'((1330 - prod) / 10);
                r.echo_valid = 1'b1;
                r.echo_byte  = clamped;
            end
            default: begin
            end
        endcase
        r.gate = p_gate;
        return r;
    endfunction

    task automatic wait_drained();
        while (gate_echo_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_PULSE_WIDTH: cfg_pulse_width = data;
            REG_LOW_CUTOFF:  cfg_low_cutoff = data;
            REG_HIGH_LIMIT:  cfg_high_limit = data[6:0];
            default: begin
            end
        endcase
    endtask

    // called and returns at a falling edge
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] lvl,
                             input logic typed, input t_result typed_res);
        int      gap;
        t_result r;
        if ($urandom_range(0, 59) == 0) calm = !calm;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_command    = cmd;
        i_level_byte = lvl;
        do @(posedge i_clk); while (o_stall);
        r = dimmer_predict(cmd, lvl);
        gate_echo_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic run_mains_traffic(input int n_beats);
        int         sent;
        int         span;
        int         roll;
        logic [7:0] lvl;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 39) == 0) begin
                i_valid = 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 85) begin
                // one mains half cycle: zero crossing, then mostly ticks
                send_beat(CMD_ZERO_CROSS, 8'($urandom), 1'b0, '0);
                sent++;
                span = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 60);
                for (int k = 0; k < span && sent < n_beats; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6) begin
                        case ($urandom_range(0, 9))
                            0, 1:    lvl = 8'($urandom_range(0, 10));
                            2, 3, 4: lvl = 8'($urandom);
                            default: lvl = 8'($urandom_range(70, 110));
                        endcase
                        send_beat(CMD_LEVEL, lvl, 1'b0, '0);
                    end else if (roll < 8) begin
                        send_beat(CMD_UNUSED, 8'($urandom), 1'b0, '0);
                    end else if (roll < 10) begin
                        send_beat(CMD_ZERO_CROSS, 8'($urandom), 1'b0, '0);
                    end else begin
                        send_beat(CMD_TICK, 8'($urandom), 1'b0, '0);
                    end
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_beat(2'($urandom), 8'($urandom), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (gate_echo_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result beat: gate=%0b echo_valid=%0b echo_byte=%0d",
                             o_gate, o_echo_valid, o_echo_byte);
                end
            end else begin
                want = gate_echo_q.pop_front();
                if (o_gate !== want.gate || o_echo_valid !== want.echo_valid ||
                    o_echo_byte !== want.echo_byte) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: gate exp %0b got %0b, echo_valid exp %0b got %0b, %s",
                                 want.gate, o_gate, want.echo_valid, o_echo_valid,
                                 $sformatf("echo_byte exp %0d got %0d",
                                           want.echo_byte, o_echo_byte));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (beats_seen != stall_seen) begin
            stall_seen = beats_seen;
            stall_left = draw_wait();
        end
        i_stall = (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row       row;
        t_result    res;
        logic [7:0] pw;
        logic [7:0] lc;
        logic [6:0] hl;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_PULSE_WIDTH;
        i_cfg_data   = 8'd0;
        i_valid      = 1'b0;
        i_command    = CMD_TICK;
        i_level_byte = 8'd0;

        cfg_pulse_width = 8'd20;
        cfg_low_cutoff  = 8'd5;
        cfg_high_limit  = 7'd99;
        p_pending       = 8'd78;
        p_active        = 8'd78;
        p_delay_cnt     = '0;
        p_delay_on      = 1'b0;
        p_pulse_cnt     = '0;
        p_pulse_on      = 1'b0;
        p_gate          = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            row            = directed[k];
            res.gate       = row.gate;
            res.echo_valid = row.echo_valid;
            res.echo_byte  = row.echo_byte;
            send_beat(row.cmd, row.lvl, row.typed, res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            i_valid = 1'b0;
            wait_drained();
            case (ph)
                0: begin pw = 8'd20;  lc = 8'd5;   hl = 7'd99;  end
                1: begin pw = 8'd1;   lc = 8'd0;   hl = 7'd102; end
                2: begin pw = 8'd255; lc = 8'd255; hl = 7'd1;   end
                3: begin pw = 8'd0;   lc = 8'd50;  hl = 7'd90;  end  // 8-bit wrap pulse
                default: begin
                    pw = 8'($urandom_range(1, 255));
                    lc = 8'($urandom_range(0, 100));
                    hl = 7'($urandom_range(1, 102));
                end
            endcase
            write_reg(REG_PULSE_WIDTH, pw);
            write_reg(REG_LOW_CUTOFF, lc);
            write_reg(REG_HIGH_LIMIT, {1'b0, hl});
            run_mains_traffic(BEATS_PER_PHASE);
        end

        i_valid = 1'b0;
        wait_drained();
        repeat (5) @(negedge i_clk);
        if (errors == 0 && gate_echo_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
